// ===== rtl/extended_gcd_diophantine_solver_assert.svh =====
// Assertion macros shared by the extended gcd solver RTL.
// Used inside modules that have aclk and aresetn in scope.
`ifndef EXTENDED_GCD_DIOPHANTINE_SOLVER_ASSERT_SVH
`define EXTENDED_GCD_DIOPHANTINE_SOLVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EGCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EGCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/egcd_pkg.sv =====
// Package for the extended gcd Diophantine solver: widths, status codes and
// the request/response structs between the sequencer and the shared divider.
package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    // Values of the recursion reach magnitude 2^(DATA_WIDTH-1), one extra bit.
    localparam int VAL_W = DATA_WIDTH + 1;
    // Bezout coefficients carry one more guard bit during the iteration.
    localparam int COEF_W = DATA_WIDTH + 2;
    localparam int PROD_W = VAL_W + COEF_W;
    localparam int PART_W = 2 * DATA_WIDTH;
    localparam int CNT_W = $clog2(VAL_W + 1);
    localparam int IN_TDATA_W = 3 * DATA_WIDTH;
    localparam int OUT_TDATA_W = 5 * DATA_WIDTH + 2 * PART_W;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_SOLVABLE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SOL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BOTH_ZERO = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] dividend;
        logic signed [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] quo;
        logic signed [VAL_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/egcd_div.sv =====
// Shared radix-2 restoring divider with truncating signed quotient and remainder.
// Depends on egcd_pkg for widths and the request/response structs.
module egcd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  egcd_pkg::div_req_t req,
    output egcd_pkg::div_rsp_t rsp
);
    import egcd_pkg::*;

    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;
    logic [VAL_W-1:0] dvd_mag;
    logic [VAL_W-1:0] dvs_mag;
    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   diff;
    logic             ge;

    assign dvd_mag = req.dividend[VAL_W-1] ? VAL_W'(-req.dividend) : req.dividend;
    assign dvs_mag = req.divisor[VAL_W-1] ? VAL_W'(-req.divisor) : req.divisor;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[VAL_W-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        quo_next = {quo_reg[VAL_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg  <= 1'b1;
                done_reg  <= 1'b0;
                cnt_reg   <= CNT_W'(VAL_W);
                rem_reg   <= '0;
                quo_reg   <= dvd_mag;
                dvs_reg   <= dvs_mag;
                neg_q_reg <= req.dividend[VAL_W-1] ^ req.divisor[VAL_W-1];
                neg_r_reg <= req.dividend[VAL_W-1];
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_q_reg ? VAL_W'(-quo_reg) : quo_reg;
    assign rsp.rem  = neg_r_reg ? VAL_W'(-rem_reg) : rem_reg;

endmodule

// ===== rtl/extended_gcd_diophantine_solver.sv =====
// Solves a*x + b*y = c with the truncating extended Euclidean algorithm. One
// beat in gives one beat out. Each Euclid step is a pass through the shared
// radix-2 divider and then two products on the shared multiplier; after the
// loop come three final divisions. When a and b are both zero, the loop and
// the final divisions are skipped and the result is given straight away.
// The input is not ready while a beat is being worked on; a finished result
// waits in the output register while the next input beat is taken.
// Depends on egcd_pkg, egcd_div and the assertion macro header.
module extended_gcd_diophantine_solver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coef_a, coef_b, rhs_c
    input  logic [egcd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // gcd_value, bezout_x, bezout_y, part_x, part_y, step_x, step_y
    output logic [egcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status
    output logic [egcd_pkg::STATUS_W-1:0]       m_tuser
);
    import egcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_QWAIT, S_MULS, S_MULT, S_UPDT, S_BXWAIT, S_AYDIV,
        S_AYWAIT, S_CKDIV, S_CKWAIT, S_MULX, S_MULY, S_PY, S_OUT
    } state_t;

    state_t                   state_reg;
    logic signed [VAL_W-1:0]  a_reg, b_reg, c_reg;
    logic signed [VAL_W-1:0]  r0_reg, r1_reg, q_reg, k_reg;
    logic signed [COEF_W-1:0] s0_reg, s1_reg, t0_reg, t1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic [DATA_WIDTH-1:0]    stepx_reg, stepy_reg;
    logic [PART_W-1:0]        partx_reg, party_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0]      m_tuser_reg;
    logic signed [VAL_W-1:0]  in_a, in_b, in_c;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign in_a = VAL_W'(signed'(s_tdata[DATA_WIDTH-1:0]));
    assign in_b = VAL_W'(signed'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
    assign in_c = VAL_W'(signed'(s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]));

    egcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Divider operands; r0 holds the gcd once the loop has finished.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r0_reg;
        div_req.divisor  = r1_reg;
        unique case (state_reg)
            S_CHK: begin
                div_req.start = 1'b1;
                if (r1_reg == '0) begin
                    div_req.dividend = b_reg;
                    div_req.divisor  = r0_reg;
                end
            end
            S_AYDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = a_reg;
                div_req.divisor  = r0_reg;
            end
            S_CKDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = c_reg;
                div_req.divisor  = r0_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_MULS:  begin mul_a = q_reg; mul_b = s1_reg; end
            S_MULT:  begin mul_a = q_reg; mul_b = t1_reg; end
            S_MULX:  begin mul_a = k_reg; mul_b = s0_reg; end
            S_MULY:  begin mul_a = k_reg; mul_b = t0_reg; end
            default: begin mul_a = q_reg; mul_b = s1_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded instead.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        a_reg  <= in_a;
                        b_reg  <= in_b;
                        c_reg  <= in_c;
                        r0_reg <= in_a;
                        r1_reg <= in_b;
                        s0_reg <= (in_a == '0 && in_b == '0) ? '0 : COEF_W'(1);
                        s1_reg <= '0;
                        t0_reg <= '0;
                        t1_reg <= COEF_W'(1);
                        if (in_a == '0 && in_b == '0) begin
                            stepx_reg  <= '0;
                            stepy_reg  <= '0;
                            partx_reg  <= '0;
                            party_reg  <= '0;
                            status_reg <= ST_BOTH_ZERO;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    state_reg <= (r1_reg == '0) ? S_BXWAIT : S_QWAIT;
                end
                S_QWAIT: begin
                    if (div_rsp.done) begin
                        q_reg     <= div_rsp.quo;
                        r0_reg    <= r1_reg;
                        r1_reg    <= div_rsp.rem;
                        state_reg <= S_MULS;
                    end
                end
                S_MULS: begin
                    state_reg <= S_MULT;
                end
                S_MULT: begin
                    s0_reg    <= s1_reg;
                    s1_reg    <= s0_reg - prod_reg[COEF_W-1:0];
                    state_reg <= S_UPDT;
                end
                S_UPDT: begin
                    t0_reg    <= t1_reg;
                    t1_reg    <= t0_reg - prod_reg[COEF_W-1:0];
                    state_reg <= S_CHK;
                end
                S_BXWAIT: begin
                    if (div_rsp.done) begin
                        stepx_reg <= div_rsp.quo[DATA_WIDTH-1:0];
                        state_reg <= S_AYDIV;
                    end
                end
                S_AYDIV: begin
                    state_reg <= S_AYWAIT;
                end
                S_AYWAIT: begin
                    if (div_rsp.done) begin
                        stepy_reg <= DATA_WIDTH'(-div_rsp.quo);
                        state_reg <= S_CKDIV;
                    end
                end
                S_CKDIV: begin
                    state_reg <= S_CKWAIT;
                end
                S_CKWAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.rem != '0) begin
                            partx_reg  <= '0;
                            party_reg  <= '0;
                            status_reg <= ST_NO_SOL;
                            state_reg  <= S_OUT;
                        end else begin
                            k_reg      <= div_rsp.quo;
                            status_reg <= ST_SOLVABLE;
                            state_reg  <= S_MULX;
                        end
                    end
                end
                S_MULX: begin
                    state_reg <= S_MULY;
                end
                S_MULY: begin
                    partx_reg <= prod_reg[PART_W-1:0];
                    state_reg <= S_PY;
                end
                S_PY: begin
                    party_reg <= prod_reg[PART_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // The output register is free, or its beat leaves this cycle.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {stepy_reg, stepx_reg, party_reg, partx_reg,
                                         t0_reg[DATA_WIDTH-1:0], s0_reg[DATA_WIDTH-1:0],
                                         r0_reg[DATA_WIDTH-1:0]};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "extended_gcd_diophantine_solver_assert.svh"

    `EGCD_ASSERT_NXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready,
                     "ready after accept")
    `EGCD_ASSERT_IMP(a_zero_case_clear, m_tvalid && m_tuser == ST_BOTH_ZERO,
                     m_tdata == '0, "zero case not cleared")
    `EGCD_ASSERT_IMP(a_nosol_parts, m_tvalid && m_tuser == ST_NO_SOL,
                     m_tdata[3*DATA_WIDTH+2*PART_W-1:3*DATA_WIDTH] == '0,
                     "parts set without solution")
    `EGCD_ASSERT_IMP(a_div_idle_start, div_req.start,
                     !(state_reg == S_QWAIT || state_reg == S_BXWAIT ||
                       state_reg == S_AYWAIT || state_reg == S_CKWAIT),
                     "divider restarted while waiting")

endmodule
